/* hdl/positional_ordered_list_defines.svh */
// Assertion macros shared by the positional ordered list RTL
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Same-cycle property, sampled on clk_i, off while rst_ni is low
`define POL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle property: cons must hold in the cycle after ante
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pol_pkg.sv */
// Package with command, status and state codes and field widths for the positional ordered list
`default_nettype none

package pol_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_DUMP,
    S_RESP
  } state_e;

  // Field widths
  localparam int unsigned CmdW     = 3;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned PosW     = 8;
  localparam int unsigned StatW    = 2;
  localparam int unsigned OccW     = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

endpackage

`default_nettype wire

/* hdl/pol_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/positional_ordered_list.sv */
// Top level of the positional ordered list: bounded list of unsigned 32-bit words in one RAM
//
//  channel  | dir | tdata (low bit up)                          | tuser   | tlast
//  s_axis   | in  | value[31:0], position[39:32]                | command | -
//  m_axis   | out | status[1:0], occupancy[6:2], element[38:7]  | -       | last_result
//
// With the output never stalled, a refused edit or an empty dump goes straight
// to the response; an insert or delete first moves the shifted entries, the RAM
// moving one entry per cycle, then answers. A dump reads one element ahead,
// then gives one beat per cycle.
// Reset clears the count; the RAM needs no clearing pass.
// A stalled output holds the result register and stops a dump or a pending response.
`default_nettype none
`include "positional_ordered_list_defines.svh"

module positional_ordered_list #(
  parameter int DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // value[31:0], position[39:32]
  input  wire logic [pol_pkg::InDataW-1:0]     s_axis_tdata,
  // command[2:0]
  input  wire logic [pol_pkg::CmdW-1:0]        s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status[1:0], occupancy[6:2], element[38:7], zero[39]
  output logic [pol_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  pol_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    n_q, n_d;
  logic [AW-1:0]    a_q, a_d;
  logic [AW-1:0]    pa_q, pa_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [31:0]      val_q, val_d;
  pol_pkg::status_e stat_q, stat_d;

  logic             out_valid_q, out_valid_d;
  pol_pkg::status_e out_stat_q, out_stat_d;
  logic [4:0]       out_occ_q, out_occ_d;
  logic [31:0]      out_elem_q, out_elem_d;
  logic             out_last_q, out_last_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;

  logic             in_accept;
  logic             out_free;

  logic [PW-1:0]    cnt_w, pos_w, ins_p, del_p;
  pol_pkg::cmd_e    cmd;
  pol_pkg::status_e dec_status;
  pol_pkg::state_e  dec_state;
  logic [CW-1:0]    dec_cnt, dec_n;
  logic [AW-1:0]    dec_a, dec_idx;

  assign s_axis_tready = (state_q == pol_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_elem_q, out_occ_q, out_stat_q};
  assign m_axis_tlast  = out_last_q;

  // Entry store
  pol_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Decode the incoming command against the current count
  always_comb begin
    cmd   = pol_pkg::cmd_e'(s_axis_tuser);
    cnt_w = PW'(cnt_q);
    pos_w = PW'(s_axis_tdata[39:32]);
    case (cmd)
      pol_pkg::CMD_INS_FRONT: ins_p = PW'(1);
      pol_pkg::CMD_INS_BACK:  ins_p = cnt_w + PW'(1);
      default:                ins_p = pos_w;
    endcase
    case (cmd)
      pol_pkg::CMD_DEL_FRONT: del_p = PW'(1);
      pol_pkg::CMD_DEL_BACK:  del_p = cnt_w;
      default:                del_p = pos_w;
    endcase

    dec_state  = pol_pkg::S_RESP;
    dec_status = pol_pkg::STAT_BADPOS;
    dec_cnt    = cnt_q;
    dec_n      = '0;
    dec_a      = '0;
    dec_idx    = '0;
    unique case (cmd) inside
      pol_pkg::CMD_INS_FRONT, pol_pkg::CMD_INS_BACK, pol_pkg::CMD_INS_AT: begin
        if (ins_p == '0 || ins_p > cnt_w + PW'(1)) begin
          dec_status = pol_pkg::STAT_BADPOS;
        end else if (cnt_q >= CW'(DEPTH)) begin
          dec_status = pol_pkg::STAT_FULL;
        end else begin
          dec_status = pol_pkg::STAT_OK;
          dec_state  = pol_pkg::S_INS;
          dec_cnt    = cnt_q + CW'(1);
          dec_n      = CW'(cnt_w - (ins_p - PW'(1)));
          dec_a      = AW'(cnt_w - PW'(1));
          dec_idx    = AW'(ins_p - PW'(1));
        end
      end
      pol_pkg::CMD_DEL_FRONT, pol_pkg::CMD_DEL_BACK, pol_pkg::CMD_DEL_AT: begin
        if (cnt_q == '0) begin
          dec_status = pol_pkg::STAT_EMPTY;
        end else if (del_p == '0 || del_p > cnt_w) begin
          dec_status = pol_pkg::STAT_BADPOS;
        end else begin
          dec_status = pol_pkg::STAT_OK;
          dec_state  = pol_pkg::S_DEL;
          dec_cnt    = cnt_q - CW'(1);
          dec_n      = CW'(cnt_w - del_p);
          dec_a      = AW'(del_p);
        end
      end
      pol_pkg::CMD_DUMP: begin
        if (cnt_q == '0) begin
          dec_status = pol_pkg::STAT_EMPTY;
        end else begin
          dec_status = pol_pkg::STAT_OK;
          dec_state  = pol_pkg::S_DUMP;
          dec_n      = cnt_q;
        end
      end
      default: begin
        dec_status = pol_pkg::STAT_BADPOS;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pol_pkg::S_IDLE: begin
        if (in_accept) state_d = dec_state;
      end
      pol_pkg::S_INS, pol_pkg::S_DEL: begin
        if (n_q == '0 && !pend_q) state_d = pol_pkg::S_RESP;
      end
      pol_pkg::S_DUMP: begin
        if (pend_q && out_free && n_q == '0) state_d = pol_pkg::S_IDLE;
      end
      pol_pkg::S_RESP: begin
        if (out_free) state_d = pol_pkg::S_IDLE;
      end
      default: state_d = pol_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM access and result register
  always_comb begin
    cnt_d       = cnt_q;
    n_d         = n_q;
    a_d         = a_q;
    pa_d        = pa_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    val_d       = val_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_occ_d   = out_occ_q;
    out_elem_d  = out_elem_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = pa_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = a_q;

    unique case (state_q)
      pol_pkg::S_IDLE: begin
        if (in_accept) begin
          cnt_d  = dec_cnt;
          n_d    = dec_n;
          a_d    = dec_a;
          idx_d  = dec_idx;
          val_d  = s_axis_tdata[31:0];
          stat_d = dec_status;
          pend_d = 1'b0;
        end
      end
      // Move entries up one slot from the back, then drop the new value in
      pol_pkg::S_INS: begin
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (n_q != '0) begin
          ram_re = 1'b1;
          pa_d   = a_q + AW'(1);
          a_d    = a_q - AW'(1);
          n_d    = n_q - CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            ram_we    = 1'b1;
            ram_waddr = idx_q;
            ram_wdata = val_q;
          end
        end
      end
      // Move entries down one slot over the removed one
      pol_pkg::S_DEL: begin
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (n_q != '0) begin
          ram_re = 1'b1;
          pa_d   = a_q - AW'(1);
          a_d    = a_q + AW'(1);
          n_d    = n_q - CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      // Read front to back, one beat per element
      pol_pkg::S_DUMP: begin
        if (!pend_q) begin
          ram_re = 1'b1;
          a_d    = a_q + AW'(1);
          n_d    = n_q - CW'(1);
          pend_d = 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = pol_pkg::STAT_OK;
          out_occ_d   = 5'(cnt_q);
          out_elem_d  = ram_rdata;
          out_last_d  = (n_q == '0);
          if (n_q != '0) begin
            ram_re = 1'b1;
            a_d    = a_q + AW'(1);
            n_d    = n_q - CW'(1);
          end else begin
            pend_d = 1'b0;
          end
        end
      end
      pol_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_occ_d   = 5'(cnt_q);
          out_elem_d  = '0;
          out_last_d  = 1'b1;
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pol_pkg::S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    a_q        <= a_d;
    pa_q       <= pa_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    stat_q     <= stat_d;
    out_stat_q <= out_stat_d;
    out_occ_q  <= out_occ_d;
    out_elem_q <= out_elem_d;
    out_last_q <= out_last_d;
  end

  // Checks
  `POL_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "element count above depth")
  `POL_ASSERT(a_we_in_edit, ram_we |-> (state_q == pol_pkg::S_INS || state_q == pol_pkg::S_DEL), "RAM write outside an edit")
  `POL_ASSERT_NEXT(a_accept_busy, in_accept, state_q != pol_pkg::S_IDLE, "accepted command left controller idle")
  `POL_ASSERT(a_mid_dump_ok, (m_axis_tvalid && !m_axis_tlast) |-> (out_stat_q == pol_pkg::STAT_OK), "non-final beat without ok status")

endmodule

`default_nettype wire
